// ===== sv/iaids_pkg.sv =====
// shared types and codes of the indexed list with insert, delete and sort
package iaids_pkg;

   // action codes of an input item
   localparam logic [2:0] ACT_APPEND     = 3'd0;
   localparam logic [2:0] ACT_INS_BEFORE = 3'd1;
   localparam logic [2:0] ACT_INS_AFTER  = 3'd2;
   localparam logic [2:0] ACT_DELETE     = 3'd3;
   localparam logic [2:0] ACT_READ       = 3'd4;
   localparam logic [2:0] ACT_SORT_ASC   = 3'd5;
   localparam logic [2:0] ACT_SORT_DESC  = 3'd6;

   // status codes of a result item
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // operation broadcast to every cell of the row
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;
   localparam logic [1:0] CELL_SORT   = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic       descending;
      logic       phase;
   } iaids_cell_ctl_type;

endpackage

// ===== sv/indexed_array_with_insert_delete_sort.sv =====
// top level: bounded ordered list in a shifting cell row with transposition sort
//
//  channel | direction | ports                                        | handshake
//  req     | in        | req_action, req_position, req_value          | req_valid / req_ready
//  rsp     | out       | rsp_read_value, rsp_entry_count, rsp_status  | rsp_valid / rsp_ready
//
// append, insert, delete and read do not stall: the whole row shifts at once.
// a sort answers at once, then runs DEPTH odd-even transposition rounds, one per
// cycle across the cell row; no new item is taken until the last round is done.
// a result waiting on rsp_ready holds off the next item; the result register
// takes a new item in the same cycle that the last result leaves.
// reset (synchronous) empties the list; entry contents are not cleared.
module indexed_array_with_insert_delete_sort #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_position,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_value,
   output logic [4:0]  rsp_entry_count,
   output logic [1:0]  rsp_status
);
   import iaids_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CMP_BITS = (CNT_BITS > 5) ? CNT_BITS : 5;
   localparam int RND_BITS = $clog2(DEPTH);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);
   localparam logic [RND_BITS-1:0] LAST_ROUND = RND_BITS'(DEPTH - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SORT = 1'b1;

   logic                        state_ff, state_in;
   logic [RND_BITS-1:0]         round_ff, round_in;
   logic                        desc_ff, desc_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_read_value_ff, rsp_read_value_in;
   logic [4:0]                  rsp_entry_count_ff, rsp_entry_count_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;

   logic                        accept;
   logic                        full;
   logic [CMP_BITS-1:0]         pos_c;
   logic [CMP_BITS-1:0]         count_c;
   logic [CNT_BITS-1:0]         cell_pos;
   logic signed [WORD_BITS-1:0] word;
   logic signed [WORD_BITS-1:0] read_word;
   iaids_cell_ctl_type          ctl;

   logic signed [WORD_BITS-1:0] q_arr    [DEPTH];
   logic                        swap_arr [DEPTH];

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == FULL_COUNT;
   assign pos_c     = CMP_BITS'(req_position);
   assign count_c   = CMP_BITS'(count_ff);
   assign word      = WORD_BITS'($signed(req_value));
   assign read_word = q_arr[IDX_BITS'(pos_c)];

   // decode the item, drive the row and build its result
   always_comb begin
      state_in           = state_ff;
      round_in           = round_ff;
      desc_in            = desc_ff;
      count_in           = count_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_status_in      = rsp_status_ff;
      cell_pos           = CNT_BITS'(pos_c);
      ctl.op             = CELL_HOLD;
      ctl.descending     = desc_ff;
      ctl.phase          = round_ff[0];

      if (state_ff == ST_SORT) begin
         ctl.op   = CELL_SORT;
         round_in = round_ff + 1'b1;
         if (round_ff == LAST_ROUND) begin
            state_in = ST_IDLE;
            round_in = '0;
         end
      end else if (accept) begin
         rsp_valid_in      = 1'b1;
         rsp_read_value_in = '0;
         rsp_status_in     = STATUS_OK;
         case (req_action)
            ACT_APPEND: begin
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  cell_pos = count_ff;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_INS_BEFORE: begin
               if (pos_c > count_c) begin
                  rsp_status_in = STATUS_RANGE;
               end else if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_INS_AFTER: begin
               if (pos_c >= count_c) begin
                  rsp_status_in = STATUS_RANGE;
               end else if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  cell_pos = CNT_BITS'(pos_c) + 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_DELETE: begin
               if (pos_c >= count_c) begin
                  rsp_status_in = STATUS_RANGE;
               end else begin
                  ctl.op   = CELL_DELETE;
                  count_in = count_ff - 1'b1;
               end
            end
            ACT_READ: begin
               if (pos_c >= count_c) begin
                  rsp_status_in = STATUS_RANGE;
               end else begin
                  rsp_read_value_in = 32'(read_word);
               end
            end
            ACT_SORT_ASC, ACT_SORT_DESC: begin
               state_in = ST_SORT;
               round_in = '0;
               desc_in  = req_action == ACT_SORT_DESC;
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
         rsp_entry_count_in = 5'(count_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      desc_ff            <= desc_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_status_ff      <= rsp_status_in;
   end

   // the cell row
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [WORD_BITS-1:0] left_word;
      logic signed [WORD_BITS-1:0] right_word;
      logic                        left_swap;

      if (g == 0) begin : g_first
         assign left_word = '0;
         assign left_swap = 1'b0;
      end else begin : g_mid
         assign left_word = q_arr[g-1];
         assign left_swap = swap_arr[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner
         assign right_word = q_arr[g+1];
      end

      iaids_cell #(
         .INDEX     (g),
         .WORD_BITS (WORD_BITS),
         .CNT_BITS  (CNT_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pos        (cell_pos),
         .count      (count_ff),
         .word       (word),
         .left_word  (left_word),
         .right_word (right_word),
         .left_swap  (left_swap),
         .swap_out   (swap_arr[g]),
         .q          (q_arr[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== sv/iaids_cell.sv =====
// one cell of the list row: holds one entry and trades with its neighbors
module iaids_cell #(
   parameter int INDEX     = 0,
   parameter int WORD_BITS = 32,
   parameter int CNT_BITS  = 5
) (
   input  logic                            clock,
   input  iaids_pkg::iaids_cell_ctl_type   ctl,
   input  logic [CNT_BITS-1:0]             pos,
   input  logic [CNT_BITS-1:0]             count,
   input  logic signed [WORD_BITS-1:0]     word,
   input  logic signed [WORD_BITS-1:0]     left_word,
   input  logic signed [WORD_BITS-1:0]     right_word,
   input  logic                            left_swap,
   output logic                            swap_out,
   output logic signed [WORD_BITS-1:0]     q
);
   import iaids_pkg::*;

   localparam logic [CNT_BITS-1:0] MY_IDX   = CNT_BITS'(INDEX);
   localparam logic [CNT_BITS-1:0] NEXT_IDX = CNT_BITS'(INDEX + 1);
   localparam logic                PARITY   = 1'(INDEX % 2);

   logic signed [WORD_BITS-1:0] entry_ff;
   logic signed [WORD_BITS-1:0] entry_in;
   logic                        pair_ok;
   logic                        out_of_order;

   // this cell and its right neighbor are both valid and in the wrong order
   assign pair_ok      = NEXT_IDX < count;
   assign out_of_order = ctl.descending ? (entry_ff < right_word) : (entry_ff > right_word);
   assign swap_out     = pair_ok && out_of_order;

   // next entry value
   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (MY_IDX > pos) begin
               entry_in = left_word;
            end else if (MY_IDX == pos) begin
               entry_in = word;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= pos) begin
               entry_in = right_word;
            end
         end
         CELL_SORT: begin
            // left member of a pair takes from the right, right member from the left
            if (ctl.phase == PARITY) begin
               if (swap_out) begin
                  entry_in = right_word;
               end
            end else if (left_swap) begin
               entry_in = left_word;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

// ===== sv/iaids_checker.sv =====
// port checks for the indexed list, bound to the top level
module iaids_checker #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_value,
   input logic [4:0]  rsp_entry_count,
   input logic [1:0]  rsp_status
);
   import iaids_pkg::*;

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // a waiting result stays and holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_entry_count) && $stable(rsp_status))
      else $error("waiting result dropped or changed");

   // the count never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_entry_count) <= DEPTH)
      else $error("entry count above capacity");

   // a full status only comes with a full list
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_entry_count == 5'(DEPTH))
      else $error("full status with room left");

   // a failed item reads nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_read_value == '0)
      else $error("read value on a failed item");

endmodule

bind indexed_array_with_insert_delete_sort iaids_checker #(
   .DEPTH (DEPTH)
) u_iaids_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_value  (rsp_read_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_status      (rsp_status)
);
